FILE: rtl/core/sit_pkg.sv
// Shared widths and latency constants for the segment intersection test.
package sit_pkg;

    localparam int COORD_WIDTH = 16;
    // Coordinate difference, one bit wider than a coordinate
    localparam int DIFF_W  = COORD_WIDTH + 1;
    // Product of two differences
    localparam int PROD_W  = 2 * COORD_WIDTH + 2;
    // Cross or dot product (difference of two products)
    localparam int CROSS_W = 2 * COORD_WIDTH + 3;
    // Denominator, difference of two cross products
    localparam int DEN_W   = 2 * COORD_WIDTH + 4;
    // Coordinate times cross product
    localparam int NPROD_W = 3 * COORD_WIDTH + 3;
    // Numerator, difference of two such products
    localparam int NUM_W   = 3 * COORD_WIDTH + 4;
    // Quotient magnitude bits (point magnitude never exceeds 2^(W-1))
    localparam int QUOT_W  = COORD_WIDTH + 1;
    // Front-end register stages before the divider
    localparam int FRONT_STAGES = 5;
    // Divider: entry register, one stage per quotient bit, output register
    localparam int DIV_LAT = QUOT_W + 2;
    // Front stages plus divider stages, from accepted item to done strobe
    localparam int LATENCY = FRONT_STAGES + DIV_LAT;

endpackage

FILE: rtl/core/sit_div.sv
// Pipelined signed restoring divider, one quotient bit per stage.
module sit_div
    import sit_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_keep,
    input  logic signed [NUM_W-1:0]       in_num,
    input  logic signed [DEN_W-1:0]       in_den,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH-1:0] out_q
);

    logic                      valid_reg [QUOT_W+1];
    logic                      keep_reg  [QUOT_W+1];
    logic                      neg_reg   [QUOT_W+1];
    logic [DEN_W-1:0]          dmag_reg  [QUOT_W+1];
    logic [DEN_W-1:0]          rem_reg   [QUOT_W+1];
    logic [QUOT_W-1:0]         low_reg   [QUOT_W+1];
    logic [QUOT_W-1:0]         quot_reg  [QUOT_W+1];

    logic [NUM_W-1:0]          nmag;
    logic [DEN_W-1:0]          dmag;
    logic [QUOT_W-1:0]         qsigned;
    logic                      out_valid_reg;
    logic [COORD_WIDTH-1:0]    out_q_reg;
    logic [COORD_WIDTH-1:0]    out_q_next;

    // Entry: magnitudes and result sign
    assign nmag = in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
    assign dmag = in_den[DEN_W-1] ? DEN_W'(-in_den) : DEN_W'(in_den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        keep_reg[0] <= in_keep;
        neg_reg[0]  <= in_num[NUM_W-1] ^ in_den[DEN_W-1];
        dmag_reg[0] <= dmag;
        rem_reg[0]  <= DEN_W'(nmag[NUM_W-1:QUOT_W]);
        low_reg[0]  <= nmag[QUOT_W-1:0];
        quot_reg[0] <= '0;
    end

    // One compare and subtract per stage
    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_step
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [DEN_W:0]    diff;

        assign trial    = {rem_reg[k], low_reg[k][QUOT_W-1]};
        assign ge       = trial >= {1'b0, dmag_reg[k]};
        assign diff     = trial - {1'b0, dmag_reg[k]};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            keep_reg[k+1] <= keep_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            dmag_reg[k+1] <= dmag_reg[k];
            rem_reg[k+1]  <= rem_next;
            low_reg[k+1]  <= {low_reg[k][QUOT_W-2:0], 1'b0};
            quot_reg[k+1] <= {quot_reg[k][QUOT_W-2:0], ge};
        end
    end

    // Output: apply sign, zero when point not valid
    assign qsigned    = neg_reg[QUOT_W] ? (~quot_reg[QUOT_W] + 1'b1) : quot_reg[QUOT_W];
    assign out_q_next = keep_reg[QUOT_W] ? qsigned[COORD_WIDTH-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        out_q_reg <= out_q_next;
    end

    assign out_valid = out_valid_reg;
    assign out_q     = out_q_reg;

endmodule

FILE: rtl/core/segment_intersection_test.sv
// Segment intersection test: orientation pipeline feeding two point dividers.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+---------------------------
//  input   | ax ay bx by cx cy dx dy                   | start while busy low
//  result  | intersects point_valid point_x point_y    | done, one cycle, no stall
//
// One item may enter every cycle; busy is never raised.
// Each result passes through five front stages and then the divider
// (entry register, one stage per quotient bit, output register).
// Reset clears only the valid bits; results are never held back.
module segment_intersection_test
    import sit_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    input  logic signed [COORD_WIDTH-1:0] dx,
    input  logic signed [COORD_WIDTH-1:0] dy,
    output logic                          done,
    output logic                          intersects,
    output logic                          point_valid,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y
);

    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [CROSS_W-1:0]     cross_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic hit;
        logic pvalid;
    } flags_t;

    // Stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Coordinates carried to the numerator stage
    coord_t ax1_reg, ay1_reg, bx1_reg, by1_reg;
    coord_t ax2_reg, ay2_reg, bx2_reg, by2_reg;
    coord_t ax3_reg, ay3_reg, bx3_reg, by3_reg;

    // Stage 1: differences
    diff_t bax_reg, bay_reg, cax_reg, cay_reg, dax_reg, day_reg, dcx_reg, dcy_reg;
    diff_t acx_reg, acy_reg, bcx_reg, bcy_reg, adx_reg, ady_reg, bdx_reg, bdy_reg;
    diff_t cbx_reg, cby_reg, dbx_reg, dby_reg;

    // Stage 2: products
    prod_t pabc0_reg, pabc1_reg, pabd0_reg, pabd1_reg;
    prod_t pcda0_reg, pcda1_reg, pcdb0_reg, pcdb1_reg;
    prod_t pd10_reg, pd11_reg, pd20_reg, pd21_reg;
    prod_t pd30_reg, pd31_reg, pd40_reg, pd41_reg;

    // Stage 3: cross and dot sums, decision
    cross_t abc, abd, cda, cdb, dot1, dot2, dot3, dot4;
    logic   zabc, zabd, zcda, zcdb;
    logic   le1, le2, le3, le4;
    logic   hit_next;
    cross_t cda_reg, cdb_reg;
    logic   hit3_reg;

    // Stage 4: numerator products and denominator
    logic signed [NPROD_W-1:0] pbx_reg, pax_reg, pby_reg, pay_reg;
    logic signed [DEN_W-1:0]   den_next, den4_reg, den5_reg;
    flags_t                    flags4_reg, flags5_reg;

    // Stage 5: numerators
    logic signed [NUM_W-1:0] numx_reg, numy_reg;

    // Flags aligned with the divider
    flags_t flags_pipe_reg [DIV_LAT];
    logic   vx, vy;

    assign busy = 1'b0;

    // Valid chain through the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage 1: point differences
    always_ff @(posedge clk)
    begin
        ax1_reg <= ax;
        ay1_reg <= ay;
        bx1_reg <= bx;
        by1_reg <= by;
        bax_reg <= DIFF_W'(bx) - DIFF_W'(ax);
        bay_reg <= DIFF_W'(by) - DIFF_W'(ay);
        cax_reg <= DIFF_W'(cx) - DIFF_W'(ax);
        cay_reg <= DIFF_W'(cy) - DIFF_W'(ay);
        dax_reg <= DIFF_W'(dx) - DIFF_W'(ax);
        day_reg <= DIFF_W'(dy) - DIFF_W'(ay);
        dcx_reg <= DIFF_W'(dx) - DIFF_W'(cx);
        dcy_reg <= DIFF_W'(dy) - DIFF_W'(cy);
        acx_reg <= DIFF_W'(ax) - DIFF_W'(cx);
        acy_reg <= DIFF_W'(ay) - DIFF_W'(cy);
        bcx_reg <= DIFF_W'(bx) - DIFF_W'(cx);
        bcy_reg <= DIFF_W'(by) - DIFF_W'(cy);
        adx_reg <= DIFF_W'(ax) - DIFF_W'(dx);
        ady_reg <= DIFF_W'(ay) - DIFF_W'(dy);
        bdx_reg <= DIFF_W'(bx) - DIFF_W'(dx);
        bdy_reg <= DIFF_W'(by) - DIFF_W'(dy);
        cbx_reg <= DIFF_W'(cx) - DIFF_W'(bx);
        cby_reg <= DIFF_W'(cy) - DIFF_W'(by);
        dbx_reg <= DIFF_W'(dx) - DIFF_W'(bx);
        dby_reg <= DIFF_W'(dy) - DIFF_W'(by);
    end

    // Stage 2: all products of the four crosses and four dots
    always_ff @(posedge clk)
    begin
        ax2_reg   <= ax1_reg;
        ay2_reg   <= ay1_reg;
        bx2_reg   <= bx1_reg;
        by2_reg   <= by1_reg;
        pabc0_reg <= bax_reg * cay_reg;
        pabc1_reg <= bay_reg * cax_reg;
        pabd0_reg <= bax_reg * day_reg;
        pabd1_reg <= bay_reg * dax_reg;
        pcda0_reg <= dcx_reg * acy_reg;
        pcda1_reg <= dcy_reg * acx_reg;
        pcdb0_reg <= dcx_reg * bcy_reg;
        pcdb1_reg <= dcy_reg * bcx_reg;
        pd10_reg  <= acx_reg * bcx_reg;
        pd11_reg  <= acy_reg * bcy_reg;
        pd20_reg  <= adx_reg * bdx_reg;
        pd21_reg  <= ady_reg * bdy_reg;
        pd30_reg  <= cax_reg * dax_reg;
        pd31_reg  <= cay_reg * day_reg;
        pd40_reg  <= cbx_reg * dbx_reg;
        pd41_reg  <= cby_reg * dby_reg;
    end

    // Stage 3: orientations, collinear fallback and decision
    assign abc  = CROSS_W'(pabc0_reg) - CROSS_W'(pabc1_reg);
    assign abd  = CROSS_W'(pabd0_reg) - CROSS_W'(pabd1_reg);
    assign cda  = CROSS_W'(pcda0_reg) - CROSS_W'(pcda1_reg);
    assign cdb  = CROSS_W'(pcdb0_reg) - CROSS_W'(pcdb1_reg);
    assign dot1 = CROSS_W'(pd10_reg) + CROSS_W'(pd11_reg);
    assign dot2 = CROSS_W'(pd20_reg) + CROSS_W'(pd21_reg);
    assign dot3 = CROSS_W'(pd30_reg) + CROSS_W'(pd31_reg);
    assign dot4 = CROSS_W'(pd40_reg) + CROSS_W'(pd41_reg);

    assign zabc = (abc == '0);
    assign zabd = (abd == '0);
    assign zcda = (cda == '0);
    assign zcdb = (cdb == '0);
    assign le1  = dot1[CROSS_W-1] | (dot1 == '0);
    assign le2  = dot2[CROSS_W-1] | (dot2 == '0);
    assign le3  = dot3[CROSS_W-1] | (dot3 == '0);
    assign le4  = dot4[CROSS_W-1] | (dot4 == '0);

    always_comb
    begin
        if (zabc && zabd)
        begin
            // all collinear against AB: endpoint on segment
            hit_next = le1 | le2 | (zcda & le3) | (zcdb & le4);
        end
        else
        begin
            hit_next = !(!zabc && !zabd && (abc[CROSS_W-1] == abd[CROSS_W-1]))
                    && !(!zcda && !zcdb && (cda[CROSS_W-1] == cdb[CROSS_W-1]));
        end
    end

    always_ff @(posedge clk)
    begin
        ax3_reg  <= ax2_reg;
        ay3_reg  <= ay2_reg;
        bx3_reg  <= bx2_reg;
        by3_reg  <= by2_reg;
        cda_reg  <= cda;
        cdb_reg  <= cdb;
        hit3_reg <= hit_next;
    end

    // Stage 4: numerator products; acd equals cda and bcd equals cdb
    assign den_next = DEN_W'(cda_reg) - DEN_W'(cdb_reg);

    always_ff @(posedge clk)
    begin
        pbx_reg           <= bx3_reg * cda_reg;
        pax_reg           <= ax3_reg * cdb_reg;
        pby_reg           <= by3_reg * cda_reg;
        pay_reg           <= ay3_reg * cdb_reg;
        den4_reg          <= den_next;
        flags4_reg.hit    <= hit3_reg;
        flags4_reg.pvalid <= hit3_reg && (den_next != '0);
    end

    // Stage 5: numerators
    always_ff @(posedge clk)
    begin
        numx_reg   <= NUM_W'(pbx_reg) - NUM_W'(pax_reg);
        numy_reg   <= NUM_W'(pby_reg) - NUM_W'(pay_reg);
        den5_reg   <= den4_reg;
        flags5_reg <= flags4_reg;
    end

    // Flags ride alongside the divider
    always_ff @(posedge clk)
    begin
        flags_pipe_reg[0] <= flags5_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            flags_pipe_reg[i] <= flags_pipe_reg[i-1];
        end
    end

    sit_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_keep   (flags5_reg.pvalid),
        .in_num    (numx_reg),
        .in_den    (den5_reg),
        .out_valid (vx),
        .out_q     (point_x)
    );

    sit_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_keep   (flags5_reg.pvalid),
        .in_num    (numy_reg),
        .in_den    (den5_reg),
        .out_valid (vy),
        .out_q     (point_y)
    );

    assign done        = vx;
    assign intersects  = flags_pipe_reg[DIV_LAT-1].hit;
    assign point_valid = flags_pipe_reg[DIV_LAT-1].pvalid;

    // Checks
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n) vx == vy)
        else $error("divider lanes out of step");

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result missing after accepted item");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without an accepted item");

    a_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !point_valid |-> (point_x == '0) && (point_y == '0))
        else $error("point not cleared when invalid");

    a_valid_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && point_valid |-> intersects)
        else $error("point valid without intersection");

endmodule

FILE: tb/segment_intersection_test_tb.sv
// Self-checking testbench for the segment intersection test block.
module segment_intersection_test_tb;
    import sit_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic   intersects;
        logic   point_valid;
        coord_t point_x;
        coord_t point_y;
    } meet_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam coord_t CMAX = coord_t'((1 << (COORD_WIDTH - 1)) - 1);
    localparam coord_t CMIN = coord_t'(-(1 << (COORD_WIDTH - 1)));

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
    logic   done;
    logic   intersects;
    logic   point_valid;
    coord_t point_x, point_y;

    meet_t  expected_meets[$];
    int     mismatch_count = 0;
    int     idle_cycles = 0;

    segment_intersection_test dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .ax(ax), .ay(ay), .bx(bx), .by(by),
        .cx(cx), .cy(cy), .dx(dx), .dy(dy),
        .done(done), .intersects(intersects), .point_valid(point_valid),
        .point_x(point_x), .point_y(point_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Signed cross product of (p-o) and (q-o), exact at 64 bits
    function automatic longint orient(longint ox, longint oy, longint px, longint py,
                                      longint qx, longint qy);
        return (px - ox) * (qy - oy) - (py - oy) * (qx - ox);
    endfunction

    function automatic bit lies_on(longint px, longint py, longint qx, longint qy,
                                   longint rx, longint ry);
        if (orient(px, py, qx, qy, rx, ry) != 0)
            return 1'b0;
        return (px - rx) * (qx - rx) + (py - ry) * (qy - ry) <= 0;
    endfunction

    // One coordinate of the meeting point, truncated toward zero
    function automatic coord_t meet_coord(longint va, longint vb, longint acd,
                                          longint bcd, longint den);
        logic signed [127:0] num;
        logic signed [127:0] quo;
        num = 128'(vb) * 128'(acd) - 128'(va) * 128'(bcd);
        quo = num / 128'(den);
        return coord_t'(quo);
    endfunction

    function automatic meet_t predict_meet(coord_t pax, coord_t pay, coord_t pbx,
                                           coord_t pby, coord_t pcx, coord_t pcy,
                                           coord_t pdx, coord_t pdy);
        longint xa, ya, xb, yb, xc, yc, xd, yd;
        longint abc, abd, cda, cdb, acd, bcd, den;
        bit     hit;
        meet_t  m;
        xa = pax; ya = pay; xb = pbx; yb = pby;
        xc = pcx; yc = pcy; xd = pdx; yd = pdy;
        abc = orient(xa, ya, xb, yb, xc, yc);
        abd = orient(xa, ya, xb, yb, xd, yd);
        cda = orient(xc, yc, xd, yd, xa, ya);
        cdb = orient(xc, yc, xd, yd, xb, yb);
        if (abc == 0 && abd == 0)
            hit = lies_on(xa, ya, xb, yb, xc, yc) || lies_on(xa, ya, xb, yb, xd, yd)
                || lies_on(xc, yc, xd, yd, xa, ya) || lies_on(xc, yc, xd, yd, xb, yb);
        else
            hit = ((abc > 0) != (abd > 0) || abc == 0 || abd == 0)
                && ((cda > 0) != (cdb > 0) || cda == 0 || cdb == 0);
        acd = orient(xa, ya, xc, yc, xd, yd);
        bcd = orient(xb, yb, xc, yc, xd, yd);
        den = acd - bcd;
        m = '0;
        m.intersects = hit;
        if (hit && den != 0)
        begin
            m.point_valid = 1'b1;
            m.point_x = meet_coord(xa, xb, acd, bcd, den);
            m.point_y = meet_coord(ya, yb, acd, bcd, den);
        end
        return m;
    endfunction

    // Drive one segment pair and wait for it to be taken
    task automatic send_pair(coord_t pax, coord_t pay, coord_t pbx, coord_t pby,
                             coord_t pcx, coord_t pcy, coord_t pdx, coord_t pdy);
        start <= 1'b1;
        ax <= pax; ay <= pay; bx <= pbx; by <= pby;
        cx <= pcx; cy <= pcy; dx <= pdx; dy <= pdy;
        do
            @(posedge clk);
        while (busy);
        expected_meets.push_back(predict_meet(pax, pay, pbx, pby, pcx, pcy, pdx, pdy));
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return CMAX;
            1: return CMIN;
            2: return coord_t'($urandom_range(0, 15) - 8);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Field extremes, crossing, touching, parallel, collinear, degenerate
    task automatic test_directed();
        send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
        send_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
        send_pair(0, 0, 10, 10, 0, 10, 10, 0);
        send_pair(0, 0, 3, 1, 0, 1, 3, 0);
        send_pair(0, 0, 10, 0, 5, 0, 5, 7);
        send_pair(0, 0, 10, 0, 10, 0, 20, 5);
        send_pair(0, 0, 10, 0, 0, 1, 10, 1);
        send_pair(0, 0, 10, 0, 5, 0, 15, 0);
        send_pair(0, 0, 10, 0, 10, 0, 20, 0);
        send_pair(0, 0, 10, 0, 11, 0, 20, 0);
        send_pair(-5, -5, 5, 5, 0, 0, 0, 0);
        send_pair(3, 3, 3, 3, 3, 3, 3, 3);
        send_pair(3, 3, 3, 3, 4, 4, 4, 4);
        send_pair(0, 0, 10, 10, 20, 0, 12, 8);
        send_pair(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX);
        send_pair(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX);
        send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
        send_pair(-7, 2, 5, -3, -2, -6, 1, 4);
        pause_sender(1);
    endtask

    // Random pairs in bursts; some constructed crossings, some collinear, some small, the rest random
    task automatic test_random(int count);
        int     burst;
        coord_t p[8];
        for (int n = 0; n < count; )
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < count; k++, n++)
            begin
                foreach (p[i]) p[i] = rand_coord();
                case ($urandom_range(0, 4))
                    0:  // C and D mirrored through the midpoint region of AB
                    begin
                        p[4] = coord_t'($urandom_range(0, 200) - 100);
                        p[5] = -p[4];
                        p[6] = -p[4]; p[7] = p[4];
                        p[0] = coord_t'(-p[4] - 50); p[1] = coord_t'(-p[4] - 50);
                        p[2] = coord_t'(p[4] + 50); p[3] = coord_t'(p[4] + 50);
                    end
                    1:  // collinear on a shared line
                    begin
                        p[1] = p[0]; p[3] = p[0]; p[5] = p[0]; p[7] = p[0];
                    end
                    2:  // small coordinates for dense touching cases
                        foreach (p[i]) p[i] = coord_t'($urandom_range(0, 6) - 3);
                    default: ;
                endcase
                send_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 30));
        end
        start <= 1'b0;
    endtask

    // Hold off until the pipeline has drained, then send more
    task automatic test_drain();
        start <= 1'b0;
        while (expected_meets.size() != 0)
            @(posedge clk);
        test_random(30);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        meet_t exp_m;
        meet_t got;
        if (rst_n && done)
        begin
            got = {intersects, point_valid, point_x, point_y};
            if (expected_meets.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                exp_m = expected_meets.pop_front();
                if (got !== exp_m)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p got %p", exp_m, got);
                end
            end
        end
    end

    // Watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("segment_intersection_test test failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        {ax, ay, bx, by, cx, cy, dx, dy} = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400);
        test_drain();
        test_random(400);
        while (expected_meets.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0 && expected_meets.size() == 0)
            $display("segment_intersection_test test passed");
        else
            $display("segment_intersection_test test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sit_pkg.sv
rtl/core/sit_div.sv
rtl/core/segment_intersection_test.sv
tb/segment_intersection_test_tb.sv
